// ===== rtl/trups_pkg.sv =====
// ----------------------------------------------------------------------------
// trups_pkg: shared constants and arithmetic for the two-row upsampler
// Holds sample and luma widths and the 9-3-3-1 interpolation and clamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package trups_pkg;

  localparam int SAMP_W     = 16;
  localparam int LUMA_BITS  = 10;
  localparam int FRAC_SHIFT = 4;
  localparam int RND_BIAS   = 8;

  // 16 times a full-scale sample plus the bias fits in SAMP_W + 5 signed bits
  localparam int SUM_W = SAMP_W + 5;
  localparam int VAL_W = SUM_W - FRAC_SHIFT;
  localparam int ACC_W = ((VAL_W > LUMA_BITS) ? VAL_W : (LUMA_BITS + 1)) + 1;

  typedef logic signed [SAMP_W-1:0] samp_t;
  typedef logic        [LUMA_BITS-1:0] luma_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // (9p + 3q + 3r + s + bias) >>> FRAC_SHIFT, floor rounding
  function automatic val_t interp(input samp_t p, input samp_t q,
                                  input samp_t r, input samp_t s);
    logic signed [SUM_W-1:0] ep;
    logic signed [SUM_W-1:0] eq;
    logic signed [SUM_W-1:0] er;
    logic signed [SUM_W-1:0] es;
    logic signed [SUM_W-1:0] sum;
    ep  = {{(SUM_W-SAMP_W){p[SAMP_W-1]}}, p};
    eq  = {{(SUM_W-SAMP_W){q[SAMP_W-1]}}, q};
    er  = {{(SUM_W-SAMP_W){r[SAMP_W-1]}}, r};
    es  = {{(SUM_W-SAMP_W){s[SAMP_W-1]}}, s};
    sum = (ep <<< 3) + ep + (eq <<< 1) + eq + (er <<< 1) + er + es
          + SUM_W'(RND_BIAS);
    return sum[SUM_W-1:FRAC_SHIFT];
  endfunction

  // base + v, clamped to 0 .. 2^LUMA_BITS - 1
  function automatic luma_t add_clamp(input luma_t base, input val_t v);
    logic signed [ACC_W-1:0] t;
    luma_t res;
    t = {{(ACC_W-VAL_W){v[VAL_W-1]}}, v} + {{(ACC_W-LUMA_BITS){1'b0}}, base};
    if (t[ACC_W-1]) begin
      res = '0;
    end else if (|t[ACC_W-2:LUMA_BITS]) begin
      res = '1;
    end else begin
      res = t[LUMA_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trups_if.sv =====
// ----------------------------------------------------------------------------
// trups channel interfaces
// Valid/ready channels for the sample-pair requests and the luma results.
// ----------------------------------------------------------------------------
`default_nettype none

interface trups_in_if
  import trups_pkg::*;
  ();
  logic  valid;
  logic  ready;
  logic  row_start;
  samp_t upper_sample;
  samp_t lower_sample;
  luma_t base_even;
  luma_t base_odd;

  modport source (output valid, row_start, upper_sample, lower_sample,
                  base_even, base_odd, input ready);
  modport sink   (input valid, row_start, upper_sample, lower_sample,
                  base_even, base_odd, output ready);
endinterface

interface trups_out_if
  import trups_pkg::*;
  ();
  logic  valid;
  logic  ready;
  luma_t out_even;
  luma_t out_odd;

  modport source (output valid, out_even, out_odd, input ready);
  modport sink   (input valid, out_even, out_odd, output ready);
endinterface

`default_nettype wire

// ===== rtl/two_row_upsample_residual_filter.sv =====
// ----------------------------------------------------------------------------
// two_row_upsample_residual_filter
// 2x horizontal bilinear upsampler over two rows with residual add and clamp.
//
// in_ch carries one request per cycle: a sample from the upper and lower row,
// a row_start flag and two base luma values. The block keeps the previous
// sample pair; a request with row_start set (or the first one after reset)
// only primes that pair and yields no result. Every other request yields one
// result on out_ch: out_even = clamp(base_even + v0), out_odd =
// clamp(base_odd + v1), with 9-3-3-1 weights and floor rounding.
// A result passes through the input register and then the result register
// before it turns valid on out_ch.
// Throughput: one request per cycle while out_ch is not stalled; the datapath
// is a single pass of adders and a clamp between the two registers.
// When out_ch stalls, both registers hold and in_ch.ready drops only once the
// input register is full; a free input register keeps accepting.
// Reset (rst_n low, synchronous) empties both registers and clears the stored
// pair and the primed flag.
// ----------------------------------------------------------------------------
`default_nettype none

module two_row_upsample_residual_filter
  import trups_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  trups_in_if.sink    in_ch,
  trups_out_if.source out_ch
);

  // stored pair from the previous request
  samp_t prev_upper_r, prev_upper_nxt;
  samp_t prev_lower_r, prev_lower_nxt;
  logic  primed_r,     primed_nxt;

  // input register: operands of one result
  logic  s1_valid_r, s1_valid_nxt;
  samp_t s1_a0_r, s1_b0_r, s1_a1_r, s1_b1_r;
  luma_t s1_base_e_r, s1_base_o_r;

  // result register
  logic  out_valid_r, out_valid_nxt;
  luma_t out_even_r, out_odd_r;

  logic  advance;     // input register moves into the result register
  logic  in_acc;
  logic  produce;     // accepted request yields a result
  val_t  v0, v1;

  // advance whenever the result register is empty or being drained
  assign advance = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign produce = primed_r && !in_ch.row_start;

  // single-pass datapath between the two registers
  assign v0 = interp(s1_a0_r, s1_a1_r, s1_b0_r, s1_b1_r);
  assign v1 = interp(s1_a1_r, s1_a0_r, s1_b1_r, s1_b0_r);

  always_comb begin
    prev_upper_nxt = prev_upper_r;
    prev_lower_nxt = prev_lower_r;
    primed_nxt     = primed_r;
    s1_valid_nxt   = s1_valid_r;
    out_valid_nxt  = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (in_acc) begin
      // every request, priming or not, becomes the new stored pair
      prev_upper_nxt = in_ch.upper_sample;
      prev_lower_nxt = in_ch.lower_sample;
      primed_nxt     = 1'b1;
      s1_valid_nxt   = produce;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_upper_r <= '0;
      prev_lower_r <= '0;
      primed_r     <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      prev_upper_r <= prev_upper_nxt;
      prev_lower_r <= prev_lower_nxt;
      primed_r     <= primed_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers: load operands on accept, results on advance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_a0_r     <= prev_upper_r;
      s1_b0_r     <= prev_lower_r;
      s1_a1_r     <= in_ch.upper_sample;
      s1_b1_r     <= in_ch.lower_sample;
      s1_base_e_r <= in_ch.base_even;
      s1_base_o_r <= in_ch.base_odd;
    end
    if (advance && s1_valid_r) begin
      out_even_r <= add_clamp(s1_base_e_r, v0);
      out_odd_r  <= add_clamp(s1_base_o_r, v1);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_even = out_even_r;
  assign out_ch.out_odd  = out_odd_r;

  // a priming request must never fill the input register
  a_prime_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !produce) |=> !s1_valid_r)
    else $error("priming request produced a result");

  // any accepted request leaves the block primed with its pair stored
  a_pair_stored: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (primed_r && prev_upper_r == $past(in_ch.upper_sample)
                && prev_lower_r == $past(in_ch.lower_sample)))
    else $error("sample pair not stored on accept");

  // a pending operand set holds while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_a1_r)
                                  && $stable(s1_b1_r)))
    else $error("input register lost its operands under stall");

  // reset empties the pipeline and clears priming
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r && !primed_r))
    else $error("state not cleared by reset");

endmodule

`default_nettype wire
